[rtl/tpfc_pkg.sv]
// ============================================================================
// tpfc_pkg
// Shared types, widths, the format table and block arithmetic for the
// texture pitch and footprint calculator.
// ============================================================================
package tpfc_pkg;

   // Format table size and field widths
   localparam int unsigned TABLE_SIZE = 98;
   localparam int unsigned ROW_W      = 20;  // blocks across (16b) times bytes (<=16)
   localparam int unsigned PROD_W     = 32;  // blocks across times blocks down
   localparam int unsigned SLICE2D_W  = 36;  // row pitch times scanlines
   localparam int unsigned SLICE_W    = 48;  // 2D slice times depth
   localparam int unsigned SUM_W      = 38;  // sum of 2D slices over all mips
   localparam int unsigned FOOT_W     = 50;  // sum times array count

   // Block edge codes (log2 of block width or height)
   localparam logic [1:0] EDGE_1 = 2'd0;
   localparam logic [1:0] EDGE_4 = 2'd2;
   localparam logic [1:0] EDGE_8 = 2'd3;

   // Format codes with special block shapes
   localparam logic [6:0] FMT_UNKNOWN    = 7'd0;
   localparam logic [6:0] FMT_WIDE_BLOCK = 7'd66;
   localparam logic [6:0] FMT_BC_A_FIRST = 7'd68;
   localparam logic [6:0] FMT_BC_A_LAST  = 7'd82;
   localparam logic [6:0] FMT_BC_B_FIRST = 7'd92;

   // Bytes per block for each format
   localparam logic [4:0] BLOCK_BYTES [0:TABLE_SIZE-1] = '{
      5'd0,  5'd16, 5'd16, 5'd16, 5'd16, 5'd12, 5'd12, 5'd12, 5'd12, 5'd8,
      5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
      5'd8,  5'd8,  5'd8,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,
      5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,
      5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd2,  5'd2,
      5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,
      5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd4,  5'd8,  5'd8,
      5'd8,  5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd8,  5'd8,  5'd8,
      5'd16, 5'd16, 5'd16, 5'd2,  5'd2,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4,
      5'd4,  5'd4,  5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16
   };

   // Request transaction
   typedef struct packed {
      logic [6:0]  format_index;
      logic [15:0] tex_width;
      logic [15:0] tex_height;
      logic [11:0] tex_depth;
      logic [4:0]  mip_level;
      logic [4:0]  mip_total;
      logic [11:0] array_count;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [31:0] row_pitch;
      logic [15:0] scanline_count;
      logic [31:0] slice_pitch;
      logic [31:0] total_footprint;
      logic        overflow;
      logic        bad_format;
   } rsp_type;

   // Decoded format
   typedef struct packed {
      logic       bad;
      logic [4:0] bytes;
      logic [1:0] bw_lg;
      logic [1:0] bh_lg;
   } tpfc_fmt_type;

   // Item held for the whole computation
   typedef struct packed {
      logic        bad;
      logic [4:0]  bytes;
      logic [1:0]  bw_lg;
      logic [1:0]  bh_lg;
      logic [15:0] width;
      logic [15:0] height;
      logic [11:0] depth;
      logic [4:0]  level;
      logic [4:0]  mips;
      logic [11:0] arr;
   } tpfc_item_type;

   // Token passed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] prod;
   } tpfc_link_type;

   // Results at the requested mip level
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [15:0]      scan;
      logic [31:0]      slice;
      logic             ovf;
   } tpfc_lvl_type;

   // Decode a format code from the table (range check against the table only)
   function automatic tpfc_fmt_type decode_format(input logic [6:0] fmt);
      tpfc_fmt_type res;
      logic         packed_bc;
      res       = '0;
      packed_bc = ((fmt >= FMT_BC_A_FIRST) && (fmt <= FMT_BC_A_LAST)) ||
                  (fmt >= FMT_BC_B_FIRST);
      if ((fmt == FMT_UNKNOWN) || (32'(fmt) >= TABLE_SIZE)) begin
         res.bad = 1'b1;
      end else begin
         res.bytes = BLOCK_BYTES[fmt];
         res.bad   = (BLOCK_BYTES[fmt] == 5'd0);
         if (fmt == FMT_WIDE_BLOCK) begin
            res.bw_lg = EDGE_8;
         end else if (packed_bc) begin
            res.bw_lg = EDGE_4;
         end else begin
            res.bw_lg = EDGE_1;
         end
         res.bh_lg = packed_bc ? EDGE_4 : EDGE_1;
      end
      return res;
   endfunction

   // Blocks covering a dimension at a mip level; zero stays zero
   function automatic logic [15:0] blocks_at(input logic [15:0] dim,
                                             input logic [4:0]  shamt,
                                             input logic [1:0]  lg);
      logic [15:0] d;
      logic [16:0] r;
      d = dim >> shamt;
      if (d == 16'd0) begin
         d = 16'd1;
      end
      r = ({1'b0, d} + ((17'd1 << lg) - 17'd1)) >> lg;
      if (dim == 16'd0) begin
         r = '0;
      end
      return r[15:0];
   endfunction

endpackage

[rtl/tpfc_cell.sv]
// ============================================================================
// tpfc_cell
// One mip of the footprint chain: forms its own block area and folds the
// previous cell's area, scaled by bytes per block, into the running sum.
// ============================================================================
module tpfc_cell #(
   parameter int unsigned LEVEL = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tpfc_pkg::tpfc_item_type item,
   input  tpfc_pkg::tpfc_link_type link_in,
   output tpfc_pkg::tpfc_link_type link_out
);

   tpfc_pkg::tpfc_link_type link_ff, link_next_in;
   logic [15:0] bw_blocks, bh_blocks;
   logic        active;
   logic [36:0] scaled;

   // Block counts at this cell's mip
   assign bw_blocks = tpfc_pkg::blocks_at(item.width, 5'(LEVEL), item.bw_lg);
   assign bh_blocks = tpfc_pkg::blocks_at(item.height, 5'(LEVEL), item.bh_lg);
   assign active    = ({1'b0, item.mips} > 6'(LEVEL));

   // Accumulate the neighbor's area, form own area
   always_comb begin
      scaled             = 37'(link_in.prod) * 37'(item.bytes);
      link_next_in.valid = link_in.valid;
      link_next_in.sum   = link_in.sum + tpfc_pkg::SUM_W'(scaled);
      link_next_in.prod  = active ? (32'(bw_blocks) * 32'(bh_blocks)) : '0;
   end

   // Advance the token one cell per cycle
   always_ff @(posedge clock) begin
      link_ff.sum  <= link_next_in.sum;
      link_ff.prod <= link_next_in.prod;
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_next_in.valid;
      end
   end

   assign link_out = link_ff;

endmodule

[rtl/tpfc_level.sv]
// ============================================================================
// tpfc_level
// Row pitch, scanline count and slice pitch at the requested mip level,
// settled over three register stages from the held item.
// ============================================================================
module tpfc_level (
   input  logic                    clock,
   input  tpfc_pkg::tpfc_item_type item,
   output tpfc_pkg::tpfc_lvl_type  lvl
);

   logic [tpfc_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [15:0]                    scan_ff, scan_in;
   logic [tpfc_pkg::SLICE2D_W-1:0] slice2d_ff, slice2d_in;
   logic [tpfc_pkg::SLICE_W-1:0]   slice_ff, slice_in;
   logic [15:0]                    bw_blocks;

   // Block counts and row pitch at the mip level
   always_comb begin
      bw_blocks  = tpfc_pkg::blocks_at(item.width, item.level, item.bw_lg);
      row_in     = tpfc_pkg::ROW_W'(21'(bw_blocks) * 21'(item.bytes));
      scan_in    = tpfc_pkg::blocks_at(item.height, item.level, item.bh_lg);
      slice2d_in = tpfc_pkg::SLICE2D_W'(row_ff) * tpfc_pkg::SLICE2D_W'(scan_ff);
      slice_in   = tpfc_pkg::SLICE_W'(slice2d_ff) * tpfc_pkg::SLICE_W'(item.depth);
   end

   // Hold each product for the next stage
   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      scan_ff    <= scan_in;
      slice2d_ff <= slice2d_in;
      slice_ff   <= slice_in;
   end

   assign lvl.row   = row_ff;
   assign lvl.scan  = scan_ff;
   assign lvl.slice = slice_ff[31:0];
   assign lvl.ovf   = (|slice2d_ff[tpfc_pkg::SLICE2D_W-1:32]) ||
                      (|slice_ff[tpfc_pkg::SLICE_W-1:32]);

endmodule

[rtl/texture_pitch_footprint_calc.sv]
// ============================================================================
// texture_pitch_footprint_calc
// Texture row pitch, scanline count, slice pitch and mip-chain footprint.
// ============================================================================
// One transaction at a time. The footprint is summed by a chain of MAX_MIPS
// cells, one per mip level, and a token walks that chain one cell per cycle;
// two more stages then add the last mip and multiply by the array count. The
// result passes from the footprint stage into the output register, and the
// next request is accepted once the result has entered that register. The
// result register holds while rsp_stall is high and a new request can run
// meanwhile. Values wider than 32 bits keep their low bits and set overflow;
// an unknown format returns zeros with bad_format set.
// ============================================================================
module texture_pitch_footprint_calc #(
   parameter int unsigned MAX_MIPS     = 16,
   parameter int unsigned FORMAT_COUNT = 98
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tpfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tpfc_pkg::rsp_type rsp_data
);

   localparam logic [31:0] LOW32 = 32'hFFFF_FFFF;

   tpfc_pkg::tpfc_item_type item_ff, item_in;
   tpfc_pkg::tpfc_fmt_type  fmt;
   tpfc_pkg::tpfc_link_type link [0:MAX_MIPS];
   tpfc_pkg::tpfc_lvl_type  lvl;
   tpfc_pkg::rsp_type       rsp_ff, rsp_in;

   logic                        busy_ff, start_ff, sum_valid_ff, foot_valid_ff, rsp_valid_ff;
   logic [tpfc_pkg::SUM_W-1:0]  total_ff, total_in;
   logic [tpfc_pkg::FOOT_W-1:0] foot_ff, foot_in;
   logic [36:0]                 last_scaled;
   logic [MAX_MIPS-1:0]         chain_valid;
   logic                        req_accept, rsp_load;

   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = foot_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = busy_ff;

   // Decode the incoming request
   always_comb begin
      fmt             = tpfc_pkg::decode_format(req_data.format_index);
      item_in.bad     = fmt.bad || ({1'b0, req_data.format_index} >= 8'(FORMAT_COUNT));
      item_in.bytes   = fmt.bytes;
      item_in.bw_lg   = fmt.bw_lg;
      item_in.bh_lg   = fmt.bh_lg;
      item_in.width   = req_data.tex_width;
      item_in.height  = req_data.tex_height;
      item_in.depth   = req_data.tex_depth;
      item_in.level   = req_data.mip_level;
      item_in.mips    = req_data.mip_total;
      item_in.arr     = req_data.array_count;
   end

   // Feed the chain head with an empty sum
   assign link[0] = '{valid: start_ff, sum: '0, prod: '0};

   // One cell per mip level
   for (genvar k = 0; k < MAX_MIPS; k++) begin : g_cell
      tpfc_cell #(
         .LEVEL(k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .item    (item_ff),
         .link_in (link[k]),
         .link_out(link[k+1])
      );
      assign chain_valid[k] = link[k+1].valid;
   end

   // Results at the requested mip level
   tpfc_level u_level (
      .clock(clock),
      .item (item_ff),
      .lvl  (lvl)
   );

   // Fold in the last mip, then scale by the array count
   always_comb begin
      last_scaled = 37'(link[MAX_MIPS].prod) * 37'(item_ff.bytes);
      total_in    = link[MAX_MIPS].sum + tpfc_pkg::SUM_W'(last_scaled);
      foot_in     = tpfc_pkg::FOOT_W'(total_ff) * tpfc_pkg::FOOT_W'(item_ff.arr);
   end

   // Assemble the response; zero it for an unknown format
   always_comb begin
      rsp_in = '0;
      if (item_ff.bad) begin
         rsp_in.bad_format = 1'b1;
      end else begin
         rsp_in.row_pitch       = 32'(lvl.row);
         rsp_in.scanline_count  = lvl.scan;
         rsp_in.slice_pitch     = lvl.slice;
         rsp_in.total_footprint = foot_ff[31:0];
         rsp_in.overflow        = lvl.ovf ||
                                  (total_ff > tpfc_pkg::SUM_W'(LOW32)) ||
                                  (foot_ff > tpfc_pkg::FOOT_W'(LOW32));
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
      if (link[MAX_MIPS].valid) begin
         total_ff <= total_in;
      end
      if (sum_valid_ff) begin
         foot_ff <= foot_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control: launch, track the tail stages, hold the output
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         start_ff      <= 1'b0;
         sum_valid_ff  <= 1'b0;
         foot_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_ff     <= req_accept;
         sum_valid_ff <= link[MAX_MIPS].valid;
         if (req_accept) begin
            busy_ff <= 1'b1;
         end else if (rsp_load) begin
            busy_ff <= 1'b0;
         end
         if (sum_valid_ff) begin
            foot_valid_ff <= 1'b1;
         end else if (rsp_load) begin
            foot_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Only one token walks the chain at a time
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({chain_valid, start_ff}))
      else $error("more than one token in the footprint chain");

   // The chain only produces while a transaction is in flight
   a_chain_busy: assert property (@(posedge clock) disable iff (reset)
      link[MAX_MIPS].valid |-> busy_ff)
      else $error("chain output without a transaction in flight");

   // The sum stage never overtakes an unloaded footprint
   a_tail_order: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff |-> !foot_valid_ff)
      else $error("footprint stage overwritten before unload");

   // An unknown format returns all zero fields
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_format) |->
         (rsp_data.row_pitch == 32'd0) && (rsp_data.scanline_count == 16'd0) &&
         (rsp_data.slice_pitch == 32'd0) && (rsp_data.total_footprint == 32'd0) &&
         !rsp_data.overflow)
      else $error("unknown format returned nonzero fields");
`endif

endmodule
